// ===== rtl/mfps_pkg.sv =====
// ----------------------------------------------------------------------------
// mfps_pkg
// Types and constants shared by the minimum falling path sum block.
// ----------------------------------------------------------------------------
package mfps_pkg;

  localparam int VAL_W = 16;
  localparam int SUM_W = 32;
  localparam int CFG_W = 7;

  localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 7'd64;
  localparam logic [SUM_W-1:0] SUM_MAX = 32'h7fff_ffff;
  localparam logic [SUM_W-1:0] SUM_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SWEEP,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic accept;
    logic row_end;
    logic rotate;
  } cell_ctrl_t;

endpackage

// ===== rtl/mfps_cell.sv =====
// ----------------------------------------------------------------------------
// mfps_cell
// One column of the row store: a read-ahead stage and a write stage.
// ----------------------------------------------------------------------------
module mfps_cell
  import mfps_pkg::*;
#(
  parameter int IDX_W = 6,
  parameter int K     = 0
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [SUM_W-1:0] new_sum,
  input  logic [SUM_W-1:0] a_right,
  input  logic [SUM_W-1:0] b_right,
  output logic [SUM_W-1:0] a_q,
  output logic [SUM_W-1:0] b_q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(K);

  logic [SUM_W-1:0] a_r, a_nxt;
  logic [SUM_W-1:0] b_r, b_nxt;
  logic             hit;

  always_comb begin
    hit   = ctrl.accept && (wr_idx == MY_IDX);
    b_nxt = b_r;
    a_nxt = a_r;
    if (ctrl.rotate) begin
      b_nxt = b_right;
    end else if (hit) begin
      b_nxt = new_sum;
    end
    if (ctrl.accept) begin
      a_nxt = ctrl.row_end ? (hit ? new_sum : b_r) : a_right;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign a_q = a_r;
  assign b_q = b_r;

endmodule

// ===== rtl/min_falling_path_sum_top.sv =====
// ----------------------------------------------------------------------------
// min_falling_path_sum_top
// Minimum falling path sum over a grid streamed in row-major order.
// ----------------------------------------------------------------------------
// Grid cells enter on the in_ channel (in_valid / in_stall), one transfer per
// cell, with in_last_cell set on the final cell of the grid. The one result,
// the minimum falling path sum, leaves on the out_ channel the cycle after the
// last cell is taken and waits in an output register while out_stall is high.
// One cell is taken per cycle unless in_stall is high; the row store is a chain
// of MAX_COLS column cells, each reading ahead of the current column, so no
// cell waits on the one before it. Outside the rotation below, a last cell is
// held off only while an earlier result waits on a stalled receiver; others flow.
// cfg_row_width sets the row width (cfg_valid / cfg_ready), to be written
// between items. If a write narrows the row below the current column, the
// block rotates the store once around, with in_stall and cfg_ready held, to
// fetch the clamped column's sum.
// Reset (rst_n low, synchronous) restores width 64, clears the output and
// starts a new grid; the row store is not cleared and is written before use.
// ----------------------------------------------------------------------------
module min_falling_path_sum_top
  import mfps_pkg::*;
#(
  parameter int MAX_COLS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [VAL_W-1:0] in_cell_value,
  input  logic                    in_last_cell,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SUM_W-1:0] out_min_sum,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        cfg_row_width
);

  localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int W_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [W_W-1:0]   MAX_W    = W_W'(MAX_COLS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_COLS - 1);

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   row_width_r, row_width_nxt;
  logic [IDX_W-1:0]   col_r, col_nxt;
  logic               first_row_r, first_row_nxt;
  logic [SUM_W-1:0]   saved_r, saved_nxt;
  logic [SUM_W-1:0]   rowmin_r, rowmin_nxt;
  logic [IDX_W-1:0]   sweep_cnt_r, sweep_cnt_nxt;
  logic [SUM_W-1:0]   clamp_sum_r, clamp_sum_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]   out_sum_r, out_sum_nxt;

  logic [SUM_W-1:0]   a_q [MAX_COLS];
  logic [SUM_W-1:0]   b_q [MAX_COLS];
  cell_ctrl_t         ctrl;

  logic [W_W-1:0]     rw_ext, w_eff, col_ext, j_ext;
  logic [IDX_W-1:0]   j;
  logic               clamp_need, busy, hold, accept, cfg_fire;
  logic               left_ok, right_ok, row_end;
  logic [SUM_W-1:0]   above, right_sum, best;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   new_sum, new_min;

  // effective width and column
  always_comb begin
    rw_ext = W_W'(row_width_r);
    if (rw_ext == '0) begin
      w_eff = W_W'(1);
    end else if (rw_ext > MAX_W) begin
      w_eff = MAX_W;
    end else begin
      w_eff = rw_ext;
    end
    col_ext    = W_W'(col_r);
    clamp_need = (col_ext >= w_eff);
  end

  assign hold      = (state_r == ST_HOLD);
  assign busy      = (state_r == ST_SWEEP) || ((state_r == ST_RUN) && clamp_need);
  assign in_stall  = busy || (in_last_cell && out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = !busy;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // cell datapath
  always_comb begin
    j_ext     = hold ? (w_eff - W_W'(1)) : col_ext;
    j         = j_ext[IDX_W-1:0];
    left_ok   = (j_ext != '0);
    right_ok  = !hold && ((j_ext + W_W'(1)) < w_eff);
    row_end   = ((j_ext + W_W'(1)) >= w_eff);
    above     = hold ? clamp_sum_r : a_q[0];
    right_sum = (MAX_COLS > 1) ? a_q[(MAX_COLS > 1) ? 1 : 0] : a_q[0];
    best      = above;
    if (left_ok && ($signed(saved_r) < $signed(best))) begin
      best = saved_r;
    end
    if (right_ok && ($signed(right_sum) < $signed(best))) begin
      best = right_sum;
    end
    sum_wide = {{(SUM_W + 1 - VAL_W){in_cell_value[VAL_W-1]}}, in_cell_value};
    if (!first_row_r) begin
      sum_wide = sum_wide + {best[SUM_W-1], best};
    end
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      new_sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      new_sum = sum_wide[SUM_W-1:0];
    end
    new_min = ($signed(new_sum) < $signed(rowmin_r)) ? new_sum : rowmin_r;
  end

  // sequencer and grid state
  always_comb begin
    state_nxt     = state_r;
    row_width_nxt = row_width_r;
    col_nxt       = col_r;
    first_row_nxt = first_row_r;
    saved_nxt     = saved_r;
    rowmin_nxt    = rowmin_r;
    sweep_cnt_nxt = sweep_cnt_r;
    clamp_sum_nxt = clamp_sum_r;
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;
    ctrl.accept   = accept;
    ctrl.row_end  = row_end || in_last_cell;
    ctrl.rotate   = 1'b0;

    unique case (state_r)
      ST_RUN: begin
        if (clamp_need) begin
          state_nxt     = ST_SWEEP;
          sweep_cnt_nxt = '0;
        end
      end
      ST_SWEEP: begin
        ctrl.rotate   = 1'b1;
        sweep_cnt_nxt = sweep_cnt_r + IDX_W'(1);
        if (W_W'(sweep_cnt_r) == (w_eff - W_W'(1))) begin
          clamp_sum_nxt = b_q[0];
        end
        if (sweep_cnt_r == LAST_IDX) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (accept || cfg_fire) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase

    if (cfg_fire) begin
      row_width_nxt = cfg_row_width;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      if (in_last_cell) begin
        out_valid_nxt = 1'b1;
        out_sum_nxt   = new_min;
        col_nxt       = '0;
        first_row_nxt = 1'b1;
        saved_nxt     = '0;
        rowmin_nxt    = SUM_MAX;
      end else if (row_end) begin
        col_nxt       = '0;
        first_row_nxt = 1'b0;
        saved_nxt     = '0;
        rowmin_nxt    = SUM_MAX;
      end else begin
        col_nxt       = j + IDX_W'(1);
        saved_nxt     = a_q[0];
        rowmin_nxt    = new_min;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      row_width_r <= ROW_WIDTH_RST;
      col_r       <= '0;
      first_row_r <= 1'b1;
      saved_r     <= '0;
      rowmin_r    <= SUM_MAX;
      sweep_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_width_r <= row_width_nxt;
      col_r       <= col_nxt;
      first_row_r <= first_row_nxt;
      saved_r     <= saved_nxt;
      rowmin_r    <= rowmin_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clamp_sum_r <= clamp_sum_nxt;
    out_sum_r   <= out_sum_nxt;
  end

  // column cells
  for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
    localparam int NEXT = (k + 1) % MAX_COLS;
    logic [SUM_W-1:0] a_right;

    assign a_right = (k == MAX_COLS - 1) ? a_q[k] : a_q[NEXT];

    mfps_cell #(
      .IDX_W (IDX_W),
      .K     (k)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .wr_idx  (j),
      .new_sum (new_sum),
      .a_right (a_right),
      .b_right (b_q[NEXT]),
      .a_q     (a_q[k]),
      .b_q     (b_q[k])
    );
  end

  assign out_valid   = out_valid_r;
  assign out_min_sum = out_sum_r;

endmodule

// ===== rtl/mfps_checker.sv =====
// ----------------------------------------------------------------------------
// mfps_port_checker
// Port-level checks on the minimum falling path sum block, bound to the top.
// ----------------------------------------------------------------------------
module mfps_port_checker
  import mfps_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    in_last_cell,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [SUM_W-1:0] out_min_sum
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_min_sum))
    else $error("result changed while stalled");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_cell |=> out_valid)
    else $error("last cell transfer without result");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_last_cell && out_valid && out_stall |-> in_stall)
    else $error("last cell taken while result blocked");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind min_falling_path_sum_top mfps_port_checker u_mfps_checker (.*);
